// ===== rtl/cronm_pkg.sv =====
// ----------------------------------------------------------------------------
// cronm_pkg
// Shared types and constants of the schedule matcher: rule kind codes,
// field lengths and the per-field lane record carried down the pipeline.
// ----------------------------------------------------------------------------
package cronm_pkg;

    localparam int NUM_FIELDS = 5;
    localparam int VAL_W      = 6;
    localparam int RULE_W     = 64;
    localparam int CFG_IDX_W  = 3;

    localparam logic [2:0] KIND_WILD   = 3'd0;
    localparam logic [2:0] KIND_NUM    = 3'd1;
    localparam logic [2:0] KIND_RANGE  = 3'd2;
    localparam logic [2:0] KIND_REPEAT = 3'd3;
    localparam logic [2:0] KIND_LIST   = 3'd4;

    typedef logic [VAL_W-1:0] t_val;

    typedef struct packed {
        logic direct_ok;
        logic is_rep;
        logic rep_ok;
        t_val dvd;
        t_val dvs;
        t_val rem;
    } t_lane;

    // field length tested by a repeat rule at value zero; zero means none
    localparam t_val FIELD_LEN [NUM_FIELDS] = '{6'd60, 6'd24, 6'd0, 6'd0, 6'd7};

endpackage

// ===== rtl/cronm_field_eval.sv =====
// ----------------------------------------------------------------------------
// cronm_field_eval
// Decodes one field rule against one field value: settles wildcard, number,
// range and list kinds, and prepares dividend and step for a repeat rule.
// ----------------------------------------------------------------------------
module cronm_field_eval
    import cronm_pkg::*;
(
    input  logic [RULE_W-1:0] i_rule,
    input  t_val              i_val,
    input  t_val              i_len,
    output t_lane             o_lane
);

    logic [2:0] kind;
    t_val       a;
    t_val       b;
    logic [6:0] lidx;

    always_comb begin
        kind = i_rule[2:0];
        a    = i_rule[9:4];
        b    = i_rule[15:10];
        lidx = {1'b0, i_val} + 7'd4;

        o_lane     = '0;
        o_lane.dvs = a;
        o_lane.dvd = (i_val == '0) ? i_len : i_val;

        unique case (kind)
            KIND_WILD: begin
                o_lane.direct_ok = 1'b1;
            end
            KIND_NUM: begin
                o_lane.direct_ok = (a == i_val);
            end
            KIND_RANGE: begin
                o_lane.direct_ok = (a <= i_val) && (i_val <= b);
            end
            KIND_REPEAT: begin
                o_lane.is_rep = 1'b1;
                o_lane.rep_ok = (a != '0) && !((i_val == '0) && (i_len == '0));
            end
            KIND_LIST: begin
                o_lane.direct_ok = (lidx <= 7'd63) && i_rule[lidx[5:0]];
            end
            default: begin
                o_lane.direct_ok = 1'b0;
            end
        endcase
    end

endmodule

// ===== rtl/cronm_rem_pipe.sv =====
// ----------------------------------------------------------------------------
// cronm_rem_pipe
// Three-stage restoring remainder unit for all five lanes, two quotient
// bits per stage; the last stage folds the lanes into the match bit.
// ----------------------------------------------------------------------------
module cronm_rem_pipe
    import cronm_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_lane i_lane [NUM_FIELDS],
    output logic  o_out_valid,
    input  logic  i_out_ready,
    output logic  o_match
);

    function automatic t_val rem_step(input t_val r, input logic bit_in, input t_val d);
        logic [VAL_W:0] t;
        t = {r, bit_in};
        if (t >= {1'b0, d}) begin
            t = t - {1'b0, d};
        end
        return t[VAL_W-1:0];
    endfunction

    logic  r_a_vld;
    logic  r_b_vld;
    logic  r_c_vld;
    t_lane r_a_lane [NUM_FIELDS];
    t_lane r_b_lane [NUM_FIELDS];
    t_lane n_a_lane [NUM_FIELDS];
    t_lane n_b_lane [NUM_FIELDS];
    logic  r_c_match;
    logic  n_c_match;
    logic  [NUM_FIELDS-1:0] lane_ok;
    logic  rdy_a;
    logic  rdy_b;
    logic  rdy_c;
    t_val  rem_c [NUM_FIELDS];

    assign rdy_c      = !r_c_vld || i_out_ready;
    assign rdy_b      = !r_b_vld || rdy_c;
    assign rdy_a      = !r_a_vld || rdy_b;
    assign o_in_ready = rdy_a;

    always_comb begin
        for (int i = 0; i < NUM_FIELDS; i++) begin
            n_a_lane[i]     = i_lane[i];
            n_a_lane[i].rem = rem_step(rem_step(i_lane[i].rem, i_lane[i].dvd[5],
                                                i_lane[i].dvs),
                                       i_lane[i].dvd[4], i_lane[i].dvs);
            n_b_lane[i]     = r_a_lane[i];
            n_b_lane[i].rem = rem_step(rem_step(r_a_lane[i].rem, r_a_lane[i].dvd[3],
                                                r_a_lane[i].dvs),
                                       r_a_lane[i].dvd[2], r_a_lane[i].dvs);
            rem_c[i]        = rem_step(rem_step(r_b_lane[i].rem, r_b_lane[i].dvd[1],
                                                r_b_lane[i].dvs),
                                       r_b_lane[i].dvd[0], r_b_lane[i].dvs);
            lane_ok[i]      = r_b_lane[i].is_rep ? (r_b_lane[i].rep_ok && (rem_c[i] == '0))
                                                 : r_b_lane[i].direct_ok;
        end
        n_c_match = &lane_ok;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
        end else begin
            if (rdy_a) begin
                r_a_vld <= i_in_valid;
            end
            if (rdy_b) begin
                r_b_vld <= r_a_vld;
            end
            if (rdy_c) begin
                r_c_vld <= r_b_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_a) begin
            r_a_lane <= n_a_lane;
        end
        if (rdy_b) begin
            r_b_lane <= n_b_lane;
        end
        if (rdy_c) begin
            r_c_match <= n_c_match;
        end
    end

    assign o_out_valid = r_c_vld;
    assign o_match     = r_c_match;

endmodule

// ===== rtl/cron_schedule_matcher_unit.sv =====
// ----------------------------------------------------------------------------
// cron_schedule_matcher_unit
// Matches a time stamp against one five-rule schedule entry.
// ----------------------------------------------------------------------------
// One time stamp enters per cycle while the output is not stalled: one
// stage decodes the five rules, then a six-step restoring remainder unit
// for the repeat rules takes two steps in each of three stages, the last
// of which is the output register. Stalls on the output back up stage by
// stage, so empty stages still take new stamps. Rules must be written
// through the configuration port only while no stamp is in flight; the
// block does not enforce this. After reset every rule is a wildcard.
// ----------------------------------------------------------------------------
module cron_schedule_matcher_unit
    import cronm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [RULE_W-1:0]    i_cfg_wr_data,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // minute[5:0], hour[10:6], day_of_month[15:11], month[19:16], weekday[22:20]
    input  logic [23:0]          s_axis_tdata,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // match[0]
    output logic [7:0]           m_axis_tdata
);

    logic [RULE_W-1:0] r_rule [NUM_FIELDS];
    t_val              vals   [NUM_FIELDS];
    t_lane             n_s1_lane [NUM_FIELDS];
    t_lane             r_s1_lane [NUM_FIELDS];
    logic              r_s1_vld;
    logic              pipe_ready;
    logic              s1_ready;
    logic              match;

    assign vals[0] = s_axis_tdata[5:0];
    assign vals[1] = {1'b0, s_axis_tdata[10:6]};
    assign vals[2] = {1'b0, s_axis_tdata[15:11]};
    assign vals[3] = {2'b0, s_axis_tdata[19:16]};
    assign vals[4] = {3'b0, s_axis_tdata[22:20]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_FIELDS; i++) begin
                r_rule[i] <= '0;
            end
        end else if (i_cfg_wr_en && (i_cfg_index < CFG_IDX_W'(NUM_FIELDS))) begin
            r_rule[i_cfg_index] <= i_cfg_wr_data;
        end
    end

    for (genvar g = 0; g < NUM_FIELDS; g++) begin : g_eval
        cronm_field_eval u_eval (
            .i_rule (r_rule[g]),
            .i_val  (vals[g]),
            .i_len  (FIELD_LEN[g]),
            .o_lane (n_s1_lane[g])
        );
    end

    assign s1_ready      = !r_s1_vld || pipe_ready;
    assign s_axis_tready = s1_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (s1_ready) begin
            r_s1_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_ready) begin
            r_s1_lane <= n_s1_lane;
        end
    end

    cronm_rem_pipe u_rem (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (r_s1_vld),
        .o_in_ready  (pipe_ready),
        .i_lane      (r_s1_lane),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_match     (match)
    );

    assign m_axis_tdata = {7'd0, match};

endmodule

// ===== rtl/cronm_checker.sv =====
// ----------------------------------------------------------------------------
// cronm_checker
// Port-level checks of the schedule matcher, bound to the top level.
// ----------------------------------------------------------------------------
module cronm_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled output transfer changed");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[7:1] == 7'd0))
        else $error("output padding not zero");

    a_backpressure_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without output stall");

endmodule

bind cron_schedule_matcher_unit cronm_checker u_cronm_checker (.*);
